// ===== rtl/core/rle_glyph_clipped_two_color_draw_top_assert.svh =====
// Assertion macros shared by the glyph draw block.
`ifndef RLE_GLYPH_CLIPPED_TWO_COLOR_DRAW_TOP_ASSERT_SVH
`define RLE_GLYPH_CLIPPED_TWO_COLOR_DRAW_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RGD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rgd_pkg.sv =====
package rgd_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
	localparam logic [2:0] REG_CLIP_TOP     = 3'd1;
	localparam logic [2:0] REG_CLIP_LEFT    = 3'd2;
	localparam logic [2:0] REG_CLIP_WIDTH   = 3'd3;
	localparam logic [2:0] REG_CLIP_HEIGHT  = 3'd4;
	localparam logic [2:0] REG_MAIN_COLOR   = 3'd5;
	localparam logic [2:0] REG_BORDER_COLOR = 3'd6;

	// Run types and color constants.
	localparam logic [2:0]  RUN_TRANSPARENT = 3'd0;
	localparam logic [2:0]  RUN_MAIN        = 3'd7;
	localparam logic [15:0] RED_FULL_MASK   = 16'hF800;
	localparam logic [15:0] BIT11_CLEAR     = 16'hF7FF;

	// Configuration registers as seen by the decoder.
	typedef struct packed {
		logic [7:0]  glyph_width;
		logic [7:0]  clip_top;
		logic [7:0]  clip_left;
		logic [7:0]  clip_width;
		logic [7:0]  clip_height;
		logic [15:0] main_color;
		logic [15:0] border_color;
	} rgd_cfg_t;

	// One pixel span handed from the decoder to the emitter.
	typedef struct packed {
		logic        load;
		logic [4:0]  count;
		logic [7:0]  row;
		logic [15:0] color;
	} rgd_job_t;

	// A color with its top five bits all set loses bit 11.
	function automatic logic [15:0] adjust_color(input logic [15:0] c);
		logic [15:0] r;
		r = c;
		if ((c & RED_FULL_MASK) == RED_FULL_MASK) begin
			r = c & BIT11_CLEAR;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/rgd_decode.sv =====
module rgd_decode #(
	parameter int COORD_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [7:0]               s_axis_tdata,
	input  logic                     s_axis_tuser,
	input  rgd_pkg::rgd_cfg_t        cfg,
	input  logic                     emit_free,
	output rgd_pkg::rgd_job_t        job,
	output logic [COORD_BITS-1:0]    job_col
);
	import rgd_pkg::*;

	localparam int CMP_W = (COORD_BITS > 8) ? COORD_BITS : 8;

	typedef enum logic [2:0] {PH_TOP, PH_LEFT, PH_VIS, PH_RIGHT, PH_DONE} phase_t;

	typedef struct {
		phase_t                  ph;
		logic [7:0]              top;
		logic signed [10:0]      span;
		logic [COORD_BITS-1:0]   vrow;
		logic [COORD_BITS-1:0]   vcol;
	} st_t;

	// Start of a visible row, or the end of the glyph once all rows are drawn.
	function automatic st_t enter_row(input st_t s_in, input rgd_cfg_t c);
		st_t s;
		s = s_in;
		if (CMP_W'(s.vrow) >= CMP_W'(c.clip_height)) begin
			s.ph   = PH_DONE;
			s.span = '0;
		end else begin
			s.vcol = '0;
			if (c.clip_left != 8'd0) begin
				s.ph   = PH_LEFT;
				s.span = $signed({3'b000, c.clip_left});
			end else begin
				s.ph   = PH_VIS;
				s.span = $signed({3'b000, c.clip_width});
			end
		end
		return s;
	endfunction

	function automatic st_t next_line(input st_t s_in, input rgd_cfg_t c);
		st_t s;
		s = s_in;
		s.vrow = s.vrow + 1'b1;
		return enter_row(s, c);
	endfunction

	// Leaves the visible part; a run excess eats into the right part.
	function automatic st_t after_vis(input st_t s_in, input rgd_cfg_t c,
			input logic signed [10:0] excess);
		st_t s;
		logic signed [10:0] r;
		logic signed [10:0] t;
		s = s_in;
		r = $signed({3'b000, c.glyph_width}) - $signed({3'b000, c.clip_left})
			- $signed({3'b000, c.clip_width});
		t = (excess < r) ? excess : r;
		r = r - t;
		if (r > 11'sd0) begin
			s.ph   = PH_RIGHT;
			s.span = r;
		end else begin
			s = next_line(s, c);
		end
		return s;
	endfunction

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    start_s1;
	logic                    take_s1;

	phase_t                  phase_q;
	logic [7:0]              top_q;
	logic signed [10:0]      span_q;
	logic [COORD_BITS-1:0]   vrow_q;
	logic [COORD_BITS-1:0]   vcol_q;

	st_t                     st_nxt;
	logic [4:0]              take_cnt;
	logic [COORD_BITS-1:0]   emit_row;
	logic [COORD_BITS-1:0]   emit_col;

	assign take_s1       = valid_s1 && emit_free;
	assign s_axis_tready = !valid_s1 || take_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Next decoder state and the pixel span of the registered run byte.
	always_comb begin
		st_t                s;
		logic signed [10:0] len;
		logic signed [10:0] carry;
		logic signed [10:0] vis;
		logic signed [10:0] tk;

		s.ph   = phase_q;
		s.top  = top_q;
		s.span = span_q;
		s.vrow = vrow_q;
		s.vcol = vcol_q;
		len    = $signed({6'b000000, byte_s1[4:0]});
		tk     = '0;
		carry  = '0;
		vis    = '0;

		// Glyph restart, or leaving an exhausted top skip.
		if (start_s1) begin
			s.vrow = '0;
			s.vcol = '0;
			s.top  = cfg.clip_top;
			s.span = $signed({3'b000, cfg.glyph_width});
			s.ph   = PH_TOP;
			if (cfg.clip_top == 8'd0) begin
				s = enter_row(s, cfg);
			end
		end else if (s.ph == PH_TOP && s.top == 8'd0) begin
			s = enter_row(s, cfg);
		end

		emit_row = s.vrow;
		emit_col = s.vcol;

		case (s.ph)
			PH_TOP: begin
				s.span = s.span - len;
				if (s.span <= 11'sd0) begin
					s.top = s.top - 8'd1;
					if (s.top != 8'd0) begin
						s.span = $signed({3'b000, cfg.glyph_width});
					end else begin
						s = enter_row(s, cfg);
					end
				end
			end
			PH_LEFT: begin
				if (s.span >= len) begin
					s.span = s.span - len;
					if (s.span <= 11'sd0) begin
						s.ph   = PH_VIS;
						s.span = $signed({3'b000, cfg.clip_width});
					end
				end else begin
					carry  = len - s.span;
					vis    = $signed({3'b000, cfg.clip_width});
					tk     = (carry < vis) ? carry : vis;
					s.vcol = s.vcol + COORD_BITS'(tk[4:0]);
					vis    = vis - tk;
					carry  = carry - tk;
					if (carry > 11'sd0) begin
						s = after_vis(s, cfg, carry);
					end else if (vis <= 11'sd0) begin
						s = after_vis(s, cfg, 11'sd0);
					end else begin
						s.ph   = PH_VIS;
						s.span = vis;
					end
				end
			end
			PH_VIS: begin
				tk     = (len < s.span) ? len : s.span;
				s.vcol = s.vcol + COORD_BITS'(tk[4:0]);
				s.span = s.span - tk;
				if (len > tk) begin
					s = after_vis(s, cfg, len - tk);
				end else if (s.span <= 11'sd0) begin
					s = after_vis(s, cfg, 11'sd0);
				end
			end
			PH_RIGHT: begin
				if (s.span >= len) begin
					s.span = s.span - len;
					if (s.span <= 11'sd0) begin
						s = next_line(s, cfg);
					end
				end else begin
					s = next_line(s, cfg);
				end
			end
			default: begin
			end
		endcase

		take_cnt = (byte_s1[7:5] == RUN_TRANSPARENT) ? 5'd0 : tk[4:0];
		st_nxt   = s;
	end

	// Decoder state, updated once per consumed run byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOP;
			top_q   <= '0;
			span_q  <= '0;
			vrow_q  <= '0;
			vcol_q  <= '0;
		end else if (take_s1) begin
			phase_q <= st_nxt.ph;
			top_q   <= st_nxt.top;
			span_q  <= st_nxt.span;
			vrow_q  <= st_nxt.vrow;
			vcol_q  <= st_nxt.vcol;
		end
	end

	assign job.load  = take_s1 && (take_cnt != 5'd0);
	assign job.count = take_cnt;
	assign job.row   = 8'(emit_row);
	assign job.color = adjust_color((byte_s1[7:5] == RUN_MAIN) ? cfg.main_color
		: cfg.border_color);
	assign job_col   = emit_col;

endmodule

// ===== rtl/core/rgd_emit.sv =====
module rgd_emit #(
	parameter int COORD_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rgd_pkg::rgd_job_t        job,
	input  logic [COORD_BITS-1:0]    job_col,
	output logic                     emit_free,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [31:0]              m_axis_tdata,
	output logic                     m_axis_tlast
);
	import rgd_pkg::*;

	logic [4:0]              cnt_q;
	logic [7:0]              row_q;
	logic [COORD_BITS-1:0]   col_q;
	logic [15:0]             color_q;

	// Free when empty or when the last pixel leaves in this cycle.
	assign emit_free = (cnt_q == 5'd0) || (cnt_q == 5'd1 && m_axis_tready);

	// Remaining pixel count of the span on show.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (emit_free) begin
			cnt_q <= job.load ? job.count : 5'd0;
		end else if (m_axis_tready) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// Pixel payload; the column steps after each transfer.
	always_ff @(posedge clk) begin
		if (emit_free && job.load) begin
			row_q   <= job.row;
			col_q   <= job_col;
			color_q <= job.color;
		end else if (m_axis_tvalid && m_axis_tready) begin
			col_q <= col_q + 1'b1;
		end
	end

	assign m_axis_tvalid = (cnt_q != 5'd0);
	assign m_axis_tlast  = (cnt_q == 5'd1);
	assign m_axis_tdata  = {color_q, 8'(col_q), row_q};

endmodule

// ===== rtl/core/rle_glyph_clipped_two_color_draw_top.sv =====
// A run byte is held in the input register, then its span is loaded into the
// single pixel output register, from which its first pixel transfers.
// Throughput: one run byte per cycle while bytes draw at most one pixel and the output
// is not stalled; a byte of N pixels holds that register until its last pixel leaves.
// Reset (arst_n, asynchronous, active low) empties both stages, puts the decoder
// in the top skip phase with zero counters, and loads the register reset values.
module rle_glyph_clipped_two_color_draw_top #(
	parameter int COORD_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] run_byte
	input  logic        s_axis_tuser,   // [0] glyph_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] row, [15:8] column, [31:16] pixel_color
	output logic        m_axis_tlast    // last_of_run
);
	import rgd_pkg::*;

	rgd_cfg_t               cfg_q;
	rgd_job_t               job;
	logic [COORD_BITS-1:0]  job_col;
	logic                   emit_free;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width  <= 8'd1;
			cfg_q.clip_top     <= '0;
			cfg_q.clip_left    <= '0;
			cfg_q.clip_width   <= '0;
			cfg_q.clip_height  <= '0;
			cfg_q.main_color   <= '0;
			cfg_q.border_color <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data[7:0];
				REG_CLIP_TOP:     cfg_q.clip_top     <= cfg_data[7:0];
				REG_CLIP_LEFT:    cfg_q.clip_left    <= cfg_data[7:0];
				REG_CLIP_WIDTH:   cfg_q.clip_width   <= cfg_data[7:0];
				REG_CLIP_HEIGHT:  cfg_q.clip_height  <= cfg_data[7:0];
				REG_MAIN_COLOR:   cfg_q.main_color   <= cfg_data;
				REG_BORDER_COLOR: cfg_q.border_color <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rgd_decode #(
		.COORD_BITS(COORD_BITS)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cfg          (cfg_q),
		.emit_free    (emit_free),
		.job          (job),
		.job_col      (job_col)
	);

	rgd_emit #(
		.COORD_BITS(COORD_BITS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job),
		.job_col      (job_col),
		.emit_free    (emit_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	`include "rle_glyph_clipped_two_color_draw_top_assert.svh"

	// A span that is not finished keeps its next pixel on show.
	`RGD_ASSERT_NEXT(a_span_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "pixel span ended before its last pixel")
	// All pixels of one run byte share row and color.
	`RGD_ASSERT_NEXT(a_span_row_color, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tdata[7:0] == $past(m_axis_tdata[7:0]) && m_axis_tdata[31:16] == $past(m_axis_tdata[31:16]), "row or color changed inside a pixel span")
	// The color adjustment never lets all five top bits through.
	`RGD_ASSERT_NOW(a_color_adjusted, m_axis_tvalid, m_axis_tdata[31:27] != 5'h1F, "pixel color not adjusted")

endmodule
